### hw/rtl/ssk_pkg.sv
// ssk_pkg: shared types, constants and state codes for the sorted key set.
// Used by sorted_key_set and ssk_checker; depends on nothing.
`default_nettype none

package ssk_pkg;

   localparam int CAPACITY    = 1024;
   localparam int KEY_W       = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int COUNT_OUT_W = 11;

   localparam logic [CNT_W-1:0]       CAP_COUNT    = CNT_W'(CAPACITY);
   localparam logic [COUNT_OUT_W-1:0] CAP_COUNT_OUT = COUNT_OUT_W'(CAPACITY);
   localparam logic [KEY_W-1:0]       SENTINEL_KEY = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      MODE_ADD      = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_CONTAINS = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                   success;
      logic                   full_res;
      logic [COUNT_OUT_W-1:0] count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_KEY,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/ssk_ram.sv
// ssk_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module ssk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/sorted_key_set.sv
// sorted_key_set: sorted set of distinct signed keys with add/remove/contains/clear.
// Flow: clear and sentinel-key beats go straight to the result; others run a binary
//   lower-bound search, then insert or remove, moving keys one place at a time.
// One beat at a time; insert/remove cost is set by the single RAM port pair.
// Reset: synchronous, clears count and control; key store content is left as is.
// Depends on ssk_pkg and ssk_ram.
`default_nettype none

module sorted_key_set (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ssk_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ssk_pkg::rsp_type      rsp
);

   // Control state
   ssk_pkg::state_type state_ff, state_in;
   logic [ssk_pkg::CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Per-beat working registers
   logic [1:0]                      mode_ff, mode_in;
   logic signed [ssk_pkg::KEY_W-1:0] key_ff, key_in;
   logic [ssk_pkg::CNT_W-1:0]       lo_ff, lo_in;
   logic [ssk_pkg::CNT_W-1:0]       hi_ff, hi_in;
   logic [ssk_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic                            found_ff, found_in;
   logic                            succ_ff, succ_in;
   logic                            full_ff, full_in;
   ssk_pkg::rsp_type                rsp_ff, rsp_in;

   // RAM port signals
   logic                             ram_wr_en;
   logic [ssk_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [ssk_pkg::KEY_W-1:0]        ram_wr_data;
   logic [ssk_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [ssk_pkg::KEY_W-1:0]        ram_rd_data;

   // Shared compare unit and address arithmetic
   logic [ssk_pkg::CNT_W:0]   mid_sum;
   logic [ssk_pkg::CNT_W-1:0] mid;
   logic [ssk_pkg::CNT_W-1:0] idx_inc;
   logic [ssk_pkg::CNT_W-1:0] idx_dec;
   logic [ssk_pkg::CNT_W-1:0] lo_inc;
   logic                      key_less;
   logic                      key_equal;
   logic                      accept;
   logic                      slot_free;
   logic                      is_simple;

   assign accept    = req_valid && !req_stall;
   // The result register can take a new beat when empty or draining this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // Clear and the end-of-list key need no trip through the store.
   assign is_simple = (req.mode == ssk_pkg::MODE_CLEAR) ||
                      (req.key == ssk_pkg::SENTINEL_KEY);

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[ssk_pkg::CNT_W:1];
   assign idx_inc   = idx_ff + 1'b1;
   assign idx_dec   = idx_ff - 1'b1;
   assign lo_inc    = lo_ff + 1'b1;
   assign key_less  = $signed(ram_rd_data) < key_ff;
   assign key_equal = ram_rd_data == key_ff;

   ssk_ram #(
      .WIDTH (ssk_pkg::KEY_W),
      .DEPTH (ssk_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssk_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = is_simple ? ssk_pkg::ST_DONE : ssk_pkg::ST_SRCH_RD;
            end
         end
         ssk_pkg::ST_SRCH_RD: begin
            // Lower-bound search ends when the window closes.
            state_in = (lo_ff < hi_ff) ? ssk_pkg::ST_SRCH_CMP : ssk_pkg::ST_DECIDE;
         end
         ssk_pkg::ST_SRCH_CMP: begin
            state_in = ssk_pkg::ST_SRCH_RD;
         end
         ssk_pkg::ST_DECIDE: begin
            case (mode_ff)
               ssk_pkg::MODE_ADD: begin
                  if (found_ff || count_ff == ssk_pkg::CAP_COUNT) begin
                     state_in = ssk_pkg::ST_DONE;
                  end else if (lo_ff == count_ff) begin
                     state_in = ssk_pkg::ST_INS_KEY;
                  end else begin
                     state_in = ssk_pkg::ST_INS_RD;
                  end
               end
               ssk_pkg::MODE_REMOVE: begin
                  if (found_ff && lo_inc != count_ff) begin
                     state_in = ssk_pkg::ST_DEL_RD;
                  end else begin
                     state_in = ssk_pkg::ST_DONE;
                  end
               end
               default: begin
                  state_in = ssk_pkg::ST_DONE;
               end
            endcase
         end
         ssk_pkg::ST_INS_RD: begin
            state_in = ssk_pkg::ST_INS_WR;
         end
         ssk_pkg::ST_INS_WR: begin
            state_in = (idx_ff == lo_ff) ? ssk_pkg::ST_INS_KEY : ssk_pkg::ST_INS_RD;
         end
         ssk_pkg::ST_INS_KEY: begin
            state_in = ssk_pkg::ST_DONE;
         end
         ssk_pkg::ST_DEL_RD: begin
            state_in = ssk_pkg::ST_DEL_WR;
         end
         ssk_pkg::ST_DEL_WR: begin
            state_in = (idx_inc == count_ff) ? ssk_pkg::ST_DONE : ssk_pkg::ST_DEL_RD;
         end
         ssk_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = ssk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssk_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath register updates
   always_comb begin
      count_in = count_ff;
      mode_in  = mode_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      succ_in  = succ_ff;
      full_in  = full_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ssk_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = req.mode;
               key_in   = req.key;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               full_in  = 1'b0;
               succ_in  = 1'b0;
               if (req.mode == ssk_pkg::MODE_CLEAR) begin
                  count_in = '0;
                  succ_in  = 1'b1;
               end else if (req.key == ssk_pkg::SENTINEL_KEY) begin
                  // The end-of-list key always reads as present and never changes.
                  succ_in = req.mode == ssk_pkg::MODE_CONTAINS;
               end
            end
         end
         ssk_pkg::ST_SRCH_CMP: begin
            if (key_less) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            if (key_equal) begin
               found_in = 1'b1;
            end
         end
         ssk_pkg::ST_DECIDE: begin
            case (mode_ff)
               ssk_pkg::MODE_ADD: begin
                  if (!found_ff) begin
                     if (count_ff == ssk_pkg::CAP_COUNT) begin
                        full_in = 1'b1;
                     end else begin
                        succ_in = 1'b1;
                        idx_in  = count_ff - 1'b1;
                     end
                  end
               end
               ssk_pkg::MODE_REMOVE: begin
                  if (found_ff) begin
                     succ_in = 1'b1;
                     idx_in  = lo_inc;
                     // Last key needs no shifting.
                     if (lo_inc == count_ff) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  succ_in = found_ff;
               end
            endcase
         end
         ssk_pkg::ST_INS_WR: begin
            idx_in = idx_dec;
         end
         ssk_pkg::ST_INS_KEY: begin
            count_in = count_ff + 1'b1;
         end
         ssk_pkg::ST_DEL_WR: begin
            idx_in = idx_inc;
            if (idx_inc == count_ff) begin
               count_in = count_ff - 1'b1;
            end
         end
         ssk_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_in.success  = succ_ff;
               rsp_in.full_res = full_ff;
               rsp_in.count    = ssk_pkg::COUNT_OUT_W'(count_ff);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Outputs: RAM control, handshakes
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_inc[ssk_pkg::ADDR_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_addr = idx_ff[ssk_pkg::ADDR_W-1:0];
      case (state_ff)
         ssk_pkg::ST_SRCH_RD: begin
            ram_rd_addr = mid[ssk_pkg::ADDR_W-1:0];
         end
         ssk_pkg::ST_INS_WR: begin
            // Move one key up by one place.
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_inc[ssk_pkg::ADDR_W-1:0];
         end
         ssk_pkg::ST_INS_KEY: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[ssk_pkg::ADDR_W-1:0];
            ram_wr_data = key_ff;
         end
         ssk_pkg::ST_DEL_WR: begin
            // Move one key down by one place.
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_dec[ssk_pkg::ADDR_W-1:0];
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == ssk_pkg::ST_DONE && slot_free) ||
                         (rsp_valid_ff && rsp_stall);

   assign req_stall = state_ff != ssk_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssk_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      succ_ff  <= succ_in;
      full_ff  <= full_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ssk_checker.sv
// ssk_checker: port-level assertions for sorted_key_set, bound to the top level.
// Depends on ssk_pkg.
`default_nettype none

module ssk_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire ssk_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ssk_pkg::rsp_type rsp
);

   // Count never exceeds the store size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.count <= ssk_pkg::CAP_COUNT_OUT)
      else $error("count beyond capacity");

   // A refused add is never a success and only happens at capacity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.full_res) |-> (!rsp.success &&
                                       rsp.count == ssk_pkg::CAP_COUNT_OUT))
      else $error("full flag inconsistent");

   // No result beat straight out of reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result beat changed");

   // A stalled request beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req)))
      else $error("stalled request beat changed");

endmodule

bind sorted_key_set ssk_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
